FILE: hw/rtl/so_iir_pkg.sv
package so_iir_pkg;

	// field and register widths
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 18;
	localparam int STATE_W   = 24;
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 16;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int CFG_W     = (COEF_W > GAIN_W) ? COEF_W : GAIN_W;
	localparam int REG_IDX_W = 3;

	// digit-serial multiplier: one 4-bit digit of the multiplier word per cycle
	localparam int DIGIT_W     = 4;
	localparam int COEF_DIGITS = (COEF_W + DIGIT_W - 1) / DIGIT_W;
	// one spare digit so that the top digit of the unsigned gain reads as positive
	localparam int GAIN_DIGITS = (GAIN_W + DIGIT_W) / DIGIT_W;
	localparam int MAX_DIGITS  = (GAIN_DIGITS > COEF_DIGITS) ? GAIN_DIGITS : COEF_DIGITS;
	localparam int MUL_W       = MAX_DIGITS * DIGIT_W;
	localparam int DIG_CW      = $clog2(MAX_DIGITS);

	// accumulator sizing
	localparam int ACCY_W = STATE_W + COEF_W + 2;
	localparam int YR_W   = ACCY_W - COEF_FRAC;
	localparam int DATA_W = (YR_W > STATE_W) ? YR_W : STATE_W;
	localparam int PP_W   = DATA_W + DIGIT_W + 1;
	localparam int ACCX_W = SAMPLE_W + COEF_FRAC + 2;
	localparam int ACCG_W = YR_W + GAIN_W + 2;
	localparam int ACC_A  = (ACCX_W > ACCY_W) ? ACCX_W : ACCY_W;
	localparam int ACC_W  = (ACC_A > ACCG_W) ? ACC_A : ACCG_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic        [GAIN_W-1:0]   gain_t;
	typedef logic signed [STATE_W-1:0]  dly_t;
	typedef logic signed [YR_W-1:0]     yr_t;
	typedef logic signed [DATA_W-1:0]   data_t;
	typedef logic signed [PP_W-1:0]     pp_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic        [MUL_W-1:0]    mul_t;
	typedef logic        [DIG_CW-1:0]   dig_t;
	typedef logic        [CFG_W-1:0]    cfg_data_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NUM_COEF_0  = 3'd0,
		REG_NUM_COEF_1  = 3'd1,
		REG_NUM_COEF_2  = 3'd2,
		REG_DEN_COEF_1  = 3'd3,
		REG_DEN_COEF_2  = 3'd4,
		REG_OUTPUT_GAIN = 3'd5
	} reg_idx_t;

	// products in the order the sequencer runs them
	typedef enum logic [2:0] {
		OP_A1   = 3'd0,
		OP_A2   = 3'd1,
		OP_B0   = 3'd2,
		OP_B1   = 3'd3,
		OP_B2   = 3'd4,
		OP_GAIN = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_RND_W,
		ST_RND_Y,
		ST_FINAL
	} state_t;

	// controls from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic acc_set;
		logic mul_load;
		logic step;
		logic sub;
		logic top;
		dig_t digit_idx;
	} mac_ctl_t;

endpackage

FILE: hw/rtl/so_iir_ifs.sv
interface so_iir_sample_if;
	logic                  valid;
	logic                  ready;
	so_iir_pkg::sample_t   sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface so_iir_result_if;
	logic                  valid;
	logic                  ready;
	so_iir_pkg::sample_t   sample_out;
	logic                  saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

FILE: hw/rtl/so_iir_mac.sv
module so_iir_mac (
	input  logic                 clk,
	input  so_iir_pkg::mac_ctl_t ctl,
	input  so_iir_pkg::acc_t     acc_init,
	input  so_iir_pkg::mul_t     mul_word,
	input  so_iir_pkg::data_t    data,
	output so_iir_pkg::acc_t     acc
);

	so_iir_pkg::acc_t acc_q;
	so_iir_pkg::mul_t mul_q;
	logic signed [so_iir_pkg::DIGIT_W:0] digit;
	so_iir_pkg::pp_t  pp;
	so_iir_pkg::acc_t pp_ext;
	so_iir_pkg::acc_t pp_sh;
	so_iir_pkg::acc_t acc_sum;

	// low digit of the multiplier word, signed only for the top digit
	assign digit = {ctl.top & mul_q[so_iir_pkg::DIGIT_W-1], mul_q[so_iir_pkg::DIGIT_W-1:0]};

	always_comb begin
		pp      = data * digit;
		pp_ext  = so_iir_pkg::acc_t'(pp);
		pp_sh   = pp_ext << (ctl.digit_idx * so_iir_pkg::DIGIT_W);
		acc_sum = ctl.sub ? (acc_q - pp_sh) : (acc_q + pp_sh);
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_set) begin
			acc_q <= acc_init;
		end else if (ctl.step) begin
			acc_q <= acc_sum;
		end
		if (ctl.mul_load) begin
			mul_q <= mul_word;
		end else if (ctl.step) begin
			mul_q <= mul_q >> so_iir_pkg::DIGIT_W;
		end
	end

	assign acc = acc_q;

endmodule

FILE: hw/rtl/second_order_iir_section_top.sv
// second-order iir section, direct form ii, fixed point
// sample_ch: one request per signed sample; ready is high only while the section
//   is free, so one sample is in work at a time
// result_ch: one request per sample with the saturated, gain-scaled output and a
//   flag that is set when the state or the output clipped
// cfg_we/cfg_idx/cfg_data: register write port, one write per cycle, no read-back;
//   write only while no sample is in work
// timing: a sample takes 36 cycles from accept to accept, set by the shared
//   digit-serial multiply-accumulate that retires one 4-bit digit of a
//   coefficient per cycle: 5 digits for each of the five coefficients, 7 for
//   the gain, plus one rounding cycle after the feedback sum, one after the
//   feed-forward sum, one to load the result and one idle cycle that accepts
//   the next sample
// latency: the result is valid 35 cycles after its sample was accepted
// stall: a finished result waits in the output register while the next sample
//   is already taken and computed; only the final load waits for that register
// reset: delays clear to zero, coefficients return to b2 = 1.0, others 0,
//   gain 1.0, no result pending
module second_order_iir_section_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  so_iir_pkg::reg_idx_t     cfg_idx,
	input  so_iir_pkg::cfg_data_t    cfg_data,
	so_iir_sample_if.sink            sample_ch,
	so_iir_result_if.source          result_ch
);

	// saturation bounds in accumulator width
	localparam so_iir_pkg::acc_t W_MAX =
		{{(so_iir_pkg::ACC_W - so_iir_pkg::STATE_W + 1){1'b0}},
		 {(so_iir_pkg::STATE_W - 1){1'b1}}};
	localparam so_iir_pkg::acc_t W_MIN =
		{{(so_iir_pkg::ACC_W - so_iir_pkg::STATE_W + 1){1'b1}},
		 {(so_iir_pkg::STATE_W - 1){1'b0}}};
	localparam so_iir_pkg::acc_t S_MAX =
		{{(so_iir_pkg::ACC_W - so_iir_pkg::SAMPLE_W + 1){1'b0}},
		 {(so_iir_pkg::SAMPLE_W - 1){1'b1}}};
	localparam so_iir_pkg::acc_t S_MIN =
		{{(so_iir_pkg::ACC_W - so_iir_pkg::SAMPLE_W + 1){1'b1}},
		 {(so_iir_pkg::SAMPLE_W - 1){1'b0}}};
	// rounding offsets (add half, then floor)
	localparam so_iir_pkg::acc_t HALF_F = so_iir_pkg::acc_t'(1) << (so_iir_pkg::COEF_FRAC - 1);
	localparam so_iir_pkg::acc_t HALF_G = so_iir_pkg::acc_t'(1) << (so_iir_pkg::GAIN_FRAC - 1);
	localparam so_iir_pkg::dig_t LAST_COEF_DIG = so_iir_pkg::dig_t'(so_iir_pkg::COEF_DIGITS - 1);
	localparam so_iir_pkg::dig_t LAST_GAIN_DIG = so_iir_pkg::dig_t'(so_iir_pkg::GAIN_DIGITS - 1);

	// configuration registers
	so_iir_pkg::coef_t b0_q, b1_q, b2_q, a1_q, a2_q;
	so_iir_pkg::gain_t gain_q;

	// sequencer
	so_iir_pkg::state_t state_q, state_nxt;
	so_iir_pkg::op_t    op_q, op_nxt;
	so_iir_pkg::dig_t   dig_q;
	so_iir_pkg::dig_t   last_dig;
	logic               digit_done;
	logic               in_accept;
	logic               final_go;
	logic               ready;

	// filter state and intermediate values
	so_iir_pkg::dly_t   d1_q, d2_q;
	so_iir_pkg::dly_t   w_q;
	so_iir_pkg::yr_t    yr_q;
	logic               clip_q;

	// output register
	logic               out_valid_q;
	so_iir_pkg::sample_t out_sample_q;
	logic               out_sat_q;

	// datapath
	so_iir_pkg::mac_ctl_t ctl;
	so_iir_pkg::acc_t   acc;
	so_iir_pkg::acc_t   acc_init;
	so_iir_pkg::mul_t   mul_word;
	so_iir_pkg::data_t  mac_data;
	so_iir_pkg::acc_t   rnd_f;
	so_iir_pkg::acc_t   rnd_g;
	so_iir_pkg::dly_t   w_sat;
	logic               w_clip;
	so_iir_pkg::sample_t y_sat;
	logic               y_clip;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q   <= '0;
			b1_q   <= '0;
			b2_q   <= so_iir_pkg::coef_t'(1) << so_iir_pkg::COEF_FRAC;
			a1_q   <= '0;
			a2_q   <= '0;
			gain_q <= so_iir_pkg::gain_t'(1) << so_iir_pkg::GAIN_FRAC;
		end else if (cfg_we) begin
			case (cfg_idx)
				so_iir_pkg::REG_NUM_COEF_0:  b0_q   <= cfg_data[so_iir_pkg::COEF_W-1:0];
				so_iir_pkg::REG_NUM_COEF_1:  b1_q   <= cfg_data[so_iir_pkg::COEF_W-1:0];
				so_iir_pkg::REG_NUM_COEF_2:  b2_q   <= cfg_data[so_iir_pkg::COEF_W-1:0];
				so_iir_pkg::REG_DEN_COEF_1:  a1_q   <= cfg_data[so_iir_pkg::COEF_W-1:0];
				so_iir_pkg::REG_DEN_COEF_2:  a2_q   <= cfg_data[so_iir_pkg::COEF_W-1:0];
				so_iir_pkg::REG_OUTPUT_GAIN: gain_q <= cfg_data[so_iir_pkg::GAIN_W-1:0];
				default: begin
					// index beyond the register list: write dropped
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign last_dig   = (op_q == so_iir_pkg::OP_GAIN) ? LAST_GAIN_DIG : LAST_COEF_DIG;
	assign digit_done = (dig_q == last_dig);
	assign in_accept  = sample_ch.valid && ready;
	assign final_go   = (state_q == so_iir_pkg::ST_FINAL) && (!out_valid_q || result_ch.ready);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			so_iir_pkg::ST_IDLE: begin
				if (sample_ch.valid) state_nxt = so_iir_pkg::ST_MAC;
			end
			so_iir_pkg::ST_MAC: begin
				if (digit_done) begin
					case (op_q)
						so_iir_pkg::OP_A2:   state_nxt = so_iir_pkg::ST_RND_W;
						so_iir_pkg::OP_B2:   state_nxt = so_iir_pkg::ST_RND_Y;
						so_iir_pkg::OP_GAIN: state_nxt = so_iir_pkg::ST_FINAL;
						default:             state_nxt = so_iir_pkg::ST_MAC;
					endcase
				end
			end
			so_iir_pkg::ST_RND_W: state_nxt = so_iir_pkg::ST_MAC;
			so_iir_pkg::ST_RND_Y: state_nxt = so_iir_pkg::ST_MAC;
			so_iir_pkg::ST_FINAL: begin
				if (!out_valid_q || result_ch.ready) state_nxt = so_iir_pkg::ST_IDLE;
			end
			default: state_nxt = so_iir_pkg::ST_IDLE;
		endcase
	end

	// product that follows the current one
	always_comb begin
		case (op_q)
			so_iir_pkg::OP_A1: op_nxt = so_iir_pkg::OP_A2;
			so_iir_pkg::OP_A2: op_nxt = so_iir_pkg::OP_B0;
			so_iir_pkg::OP_B0: op_nxt = so_iir_pkg::OP_B1;
			so_iir_pkg::OP_B1: op_nxt = so_iir_pkg::OP_B2;
			so_iir_pkg::OP_B2: op_nxt = so_iir_pkg::OP_GAIN;
			default:           op_nxt = so_iir_pkg::OP_A1;
		endcase
		if (state_q == so_iir_pkg::ST_IDLE) op_nxt = so_iir_pkg::OP_A1;
	end

	// sequencer outputs
	always_comb begin
		ready         = 1'b0;
		ctl           = '0;
		ctl.digit_idx = dig_q;
		ctl.top       = digit_done;
		acc_init      = '0;
		case (state_q)
			so_iir_pkg::ST_IDLE: begin
				ready = 1'b1;
				// the sample enters the feedback sum scaled to the coefficient lsb
				ctl.acc_set  = sample_ch.valid;
				ctl.mul_load = sample_ch.valid;
				acc_init     = so_iir_pkg::acc_t'(sample_ch.sample_in) <<< so_iir_pkg::COEF_FRAC;
			end
			so_iir_pkg::ST_MAC: begin
				ctl.step     = 1'b1;
				ctl.sub      = (op_q == so_iir_pkg::OP_A1) || (op_q == so_iir_pkg::OP_A2);
				ctl.mul_load = digit_done &&
					((op_q == so_iir_pkg::OP_A1) || (op_q == so_iir_pkg::OP_B0) ||
					 (op_q == so_iir_pkg::OP_B1));
			end
			so_iir_pkg::ST_RND_W, so_iir_pkg::ST_RND_Y: begin
				ctl.acc_set  = 1'b1;
				ctl.mul_load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= so_iir_pkg::ST_IDLE;
			op_q    <= so_iir_pkg::OP_A1;
			dig_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.mul_load) op_q <= op_nxt;
			if ((state_q == so_iir_pkg::ST_MAC) && !digit_done) begin
				dig_q <= dig_q + 1'b1;
			end else begin
				dig_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- operands
	// multiplier word of the product about to start, sign or zero extended
	always_comb begin
		case (op_nxt)
			so_iir_pkg::OP_A1:   mul_word = so_iir_pkg::mul_t'(a1_q);
			so_iir_pkg::OP_A2:   mul_word = so_iir_pkg::mul_t'(a2_q);
			so_iir_pkg::OP_B0:   mul_word = so_iir_pkg::mul_t'(b0_q);
			so_iir_pkg::OP_B1:   mul_word = so_iir_pkg::mul_t'(b1_q);
			so_iir_pkg::OP_B2:   mul_word = so_iir_pkg::mul_t'(b2_q);
			so_iir_pkg::OP_GAIN: mul_word = {{(so_iir_pkg::MUL_W - so_iir_pkg::GAIN_W){1'b0}}, gain_q};
			default:             mul_word = '0;
		endcase
	end

	// data operand of the running product; delays hold their old values until the end
	always_comb begin
		case (op_q)
			so_iir_pkg::OP_A1:   mac_data = so_iir_pkg::data_t'(d1_q);
			so_iir_pkg::OP_A2:   mac_data = so_iir_pkg::data_t'(d2_q);
			so_iir_pkg::OP_B0:   mac_data = so_iir_pkg::data_t'(w_q);
			so_iir_pkg::OP_B1:   mac_data = so_iir_pkg::data_t'(d1_q);
			so_iir_pkg::OP_B2:   mac_data = so_iir_pkg::data_t'(d2_q);
			so_iir_pkg::OP_GAIN: mac_data = so_iir_pkg::data_t'(yr_q);
			default:             mac_data = '0;
		endcase
	end

	so_iir_mac u_mac (
		.clk      (clk),
		.ctl      (ctl),
		.acc_init (acc_init),
		.mul_word (mul_word),
		.data     (mac_data),
		.acc      (acc)
	);

	// ---------------------------------------------------------------- rounding
	always_comb begin
		rnd_f = (acc + HALF_F) >>> so_iir_pkg::COEF_FRAC;
		rnd_g = (acc + HALF_G) >>> so_iir_pkg::GAIN_FRAC;

		w_clip = 1'b1;
		if (rnd_f > W_MAX) begin
			w_sat = W_MAX[so_iir_pkg::STATE_W-1:0];
		end else if (rnd_f < W_MIN) begin
			w_sat = W_MIN[so_iir_pkg::STATE_W-1:0];
		end else begin
			w_sat  = rnd_f[so_iir_pkg::STATE_W-1:0];
			w_clip = 1'b0;
		end

		y_clip = 1'b1;
		if (rnd_g > S_MAX) begin
			y_sat = S_MAX[so_iir_pkg::SAMPLE_W-1:0];
		end else if (rnd_g < S_MIN) begin
			y_sat = S_MIN[so_iir_pkg::SAMPLE_W-1:0];
		end else begin
			y_sat  = rnd_g[so_iir_pkg::SAMPLE_W-1:0];
			y_clip = 1'b0;
		end
	end

	// intermediate values, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == so_iir_pkg::ST_RND_W) w_q  <= w_sat;
		if (state_q == so_iir_pkg::ST_RND_Y) yr_q <= rnd_f[so_iir_pkg::YR_W-1:0];
	end

	// ---------------------------------------------------------------- state and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q        <= '0;
			d2_q        <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				clip_q <= 1'b0;
			end else if ((state_q == so_iir_pkg::ST_RND_W) && w_clip) begin
				clip_q <= 1'b1;
			end
			if (final_go) begin
				// delays shift only once the whole sample is done
				d2_q        <= d1_q;
				d1_q        <= w_q;
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (final_go) begin
			out_sample_q <= y_sat;
			out_sat_q    <= clip_q | y_clip;
		end
	end

	assign sample_ch.ready      = ready;
	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_sample_q;
	assign result_ch.saturated  = out_sat_q;

endmodule

FILE: hw/rtl/so_iir_chk.sv
module so_iir_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input so_iir_pkg::sample_t sample_out,
	input logic                saturated
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// samples taken whose result has not yet been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (!in_acc && out_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
		else $error("result changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("sample accepted while another is in work");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result offered with no sample pending");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !in_ready)
		else $error("ready while a sample is in work and a result waits");

endmodule

bind second_order_iir_section_top so_iir_chk u_so_iir_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.sample_out (result_ch.sample_out),
	.saturated  (result_ch.saturated)
);
